>>> sv/bmhq_pkg.sv
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int PRIO_W = 32;
    localparam int ITEM_W = 32;
    localparam int CNT_W  = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [PRIO_W-1:0] new_priority;
        logic signed [ITEM_W-1:0] new_item;
    } t_cmd;

    typedef struct packed {
        logic signed [PRIO_W-1:0] top_priority;
        logic signed [ITEM_W-1:0] top_item;
        logic        [CNT_W-1:0]  entry_count;
        logic                     is_empty;
        logic                     is_full;
        logic                     op_error;
    } t_result;

    // one heap slot
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [ITEM_W-1:0] item;
    } t_entry;

    // token kinds walking down the level chain
    typedef enum logic [1:0] {
        TOK_INS,
        TOK_ROOT,
        TOK_SIFT
    } t_op;

    typedef struct packed {
        logic   valid;
        t_op    op;
        logic   shift;
        t_entry ent;
    } t_tok;

    // write-back of a promoted child into the level above
    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_wb;

endpackage

>>> sv/binary_max_heap_queue.sv
// Insert runs from acceptance to the result strobe down the level chain to T, the tree level
// of the new slot; remove runs until the moved entry settles at level S (the bottom level at
// worst); removing the last entry or a rejected op skips the level chain.
// Throughput: one transaction in flight; a new start is taken in the strobe cycle. Worst
// case is set by the level chain depth LEVELS = clog2(CAPACITY+1).
// Reset: synchronous, active low, empties the heap; the receiver cannot stall the strobe.
`timescale 1ns / 1ps

module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_strobe,
    output t_result o_result
);

    // One cell per tree level. Slot s sits on level floor(log2(s+1)); each cell stores
    // its level as sibling pairs so a sift-down step reads both children in one access.
    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int CW     = LEVELS;
    localparam int IW     = LEVELS - 1;
    localparam int LW     = $clog2(LEVELS);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_RUN,
        S_READ,
        S_REPORT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic            r_err;
    t_tok            r_tok0;
    logic [CW-1:0]   r_path;
    logic [LW-1:0]   r_tgt;
    logic [LW-1:0]   r_acc_lvl;

    t_tok            w_tok     [LEVELS];
    logic [IW-1:0]   w_idx     [LEVELS];
    t_wb             w_wb      [LEVELS];
    logic [IW-1:0]   w_wb_idx  [LEVELS];
    t_entry          w_acc     [LEVELS];
    logic [LEVELS-1:0] w_done;

    logic            acc_rd;
    logic [LW-1:0]   acc_lvl;
    logic [IW-1:0]   acc_idx;
    logic [CW-1:0]   cnt_inc;
    logic [LW-1:0]   ins_lvl;
    logic [LW-1:0]   rem_lvl;
    logic [IW-1:0]   rem_idx;
    logic            take;

    function automatic logic [LW-1:0] msb_pos(input logic [CW-1:0] x);
        logic [LW-1:0] pos;
        pos = '0;
        for (int k = 0; k < CW; k++) begin
            if (x[k]) begin
                pos = LW'(k);
            end
        end
        return pos;
    endfunction

    assign busy = (r_state != S_IDLE);
    assign take = start && !busy;

    // level of the new slot (insert), level and in-level index of the last slot (remove)
    assign cnt_inc = r_cnt + CW'(1);
    assign ins_lvl = msb_pos(cnt_inc);
    assign rem_lvl = msb_pos(r_cnt);
    assign rem_idx = IW'(r_cnt ^ (CW'(1) << rem_lvl));

    // direct read port: last entry on remove, root before the report
    always_comb begin
        acc_rd  = 1'b0;
        acc_lvl = rem_lvl;
        acc_idx = rem_idx;
        if (r_state == S_READ) begin
            acc_rd  = 1'b1;
            acc_lvl = '0;
            acc_idx = '0;
        end else if (take && (i_cmd.opcode == OP_REMOVE) && (r_cnt != '0)) begin
            acc_rd = 1'b1;
        end
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        t_tok          tok_in;
        logic [IW-1:0] idx_in;
        t_wb           wb_in;
        logic [IW-1:0] wb_idx_in;

        if (g == 0) begin : g_head
            assign tok_in = r_tok0;
            assign idx_in = '0;
        end else begin : g_link
            assign tok_in = w_tok[g-1];
            assign idx_in = w_idx[g-1];
        end

        if (g == LEVELS - 1) begin : g_tail
            assign wb_in     = '0;
            assign wb_idx_in = '0;
        end else begin : g_back
            assign wb_in     = w_wb[g+1];
            assign wb_idx_in = w_wb_idx[g+1];
        end

        bmhq_cell #(
            .LEVEL  (g),
            .LEVELS (LEVELS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (tok_in),
            .i_idx     (idx_in),
            .o_tok     (w_tok[g]),
            .o_idx     (w_idx[g]),
            .i_wb      (wb_in),
            .i_wb_idx  (wb_idx_in),
            .o_wb      (w_wb[g]),
            .o_wb_idx  (w_wb_idx[g]),
            .i_cnt     (r_cnt),
            .i_path    (r_path),
            .i_tgt_lvl (r_tgt),
            .i_acc_rd  (acc_rd),
            .i_acc_lvl (acc_lvl),
            .i_acc_idx (acc_idx),
            .o_acc_ent (w_acc[g]),
            .o_done    (w_done[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_err        <= 1'b0;
            r_tok0.valid <= 1'b0;
            o_strobe     <= 1'b0;
        end else begin
            r_tok0.valid <= 1'b0;
            o_strobe     <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_err <= 1'b0;
                        if (i_cmd.opcode == OP_INSERT) begin
                            if (r_cnt == FULL_CNT) begin
                                r_err   <= 1'b1;
                                r_state <= S_READ;
                            end else begin
                                // top-down insert along the path to the new slot
                                r_tok0.valid     <= 1'b1;
                                r_tok0.op        <= TOK_INS;
                                r_tok0.shift     <= 1'b0;
                                r_tok0.ent.prio  <= i_cmd.new_priority;
                                r_tok0.ent.item  <= i_cmd.new_item;
                                r_path  <= cnt_inc << (LW'(LEVELS - 1) - ins_lvl);
                                r_tgt   <= ins_lvl;
                                r_cnt   <= cnt_inc;
                                r_state <= S_RUN;
                            end
                        end else begin
                            if (r_cnt == '0) begin
                                r_err   <= 1'b1;
                                r_state <= S_READ;
                            end else begin
                                r_cnt     <= r_cnt - CW'(1);
                                r_acc_lvl <= rem_lvl;
                                r_state   <= (r_cnt == CW'(1)) ? S_READ : S_FETCH;
                            end
                        end
                    end
                end
                S_FETCH: begin
                    // last entry goes to the root, then sifts down
                    r_tok0.valid <= 1'b1;
                    r_tok0.op    <= TOK_ROOT;
                    r_tok0.shift <= 1'b0;
                    r_tok0.ent   <= w_acc[r_acc_lvl];
                    r_state      <= S_RUN;
                end
                S_RUN: begin
                    if (|w_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    o_strobe <= 1'b1;
                    if (r_cnt != '0) begin
                        o_result.top_priority <= w_acc[0].prio;
                        o_result.top_item     <= w_acc[0].item;
                    end else begin
                        o_result.top_priority <= '0;
                        o_result.top_item     <= '0;
                    end
                    o_result.entry_count <= CNT_W'(r_cnt);
                    o_result.is_empty    <= (r_cnt == '0);
                    o_result.is_full     <= (r_cnt == FULL_CNT);
                    o_result.op_error    <= r_err;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/bmhq_cell.sv
`timescale 1ns / 1ps

module bmhq_cell
    import bmhq_pkg::*;
#(
    parameter int LEVEL  = 0,
    parameter int LEVELS = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_tok                      i_tok,
    input  logic [LEVELS-2:0]         i_idx,
    output t_tok                      o_tok,
    output logic [LEVELS-2:0]         o_idx,
    input  t_wb                       i_wb,
    input  logic [LEVELS-2:0]         i_wb_idx,
    output t_wb                       o_wb,
    output logic [LEVELS-2:0]         o_wb_idx,
    input  logic [LEVELS-1:0]         i_cnt,
    input  logic [LEVELS-1:0]         i_path,
    input  logic [$clog2(LEVELS)-1:0] i_tgt_lvl,
    input  logic                      i_acc_rd,
    input  logic [$clog2(LEVELS)-1:0] i_acc_lvl,
    input  logic [LEVELS-2:0]         i_acc_idx,
    output t_entry                    o_acc_ent,
    output logic                      o_done
);

    localparam int CW = LEVELS;
    localparam int IW = LEVELS - 1;
    localparam int LW = $clog2(LEVELS);
    localparam int AW = (LEVEL > 1) ? LEVEL - 1 : 1;
    localparam int DEPTH = 1 << AW;
    localparam int PB = (LEVEL <= LEVELS - 2) ? LEVELS - 2 - LEVEL : 0;
    localparam logic [CW-1:0] BASE = CW'((1 << LEVEL) - 1);
    localparam logic [LW-1:0] MY_LVL = LW'(LEVEL);

    // sibling pairs: left and right child share one address
    t_entry mem_l [DEPTH];
    t_entry mem_r [DEPTH];

    t_entry          r_rd_l;
    t_entry          r_rd_r;
    logic            r_side;
    t_tok            r_tok;
    logic [IW-1:0]   r_idx;

    logic            acc_hit;
    logic            rd_en;
    logic [AW-1:0]   raddr;

    logic            own_en;
    logic [IW-1:0]   own_idx;
    t_entry          own_ent;
    logic            wr_en;
    logic [IW-1:0]   wr_idx;
    t_entry          wr_ent;
    logic [AW-1:0]   waddr;

    t_entry          node;
    t_entry          pick;
    logic            lv;
    logic            rv;
    logic            pick_r;
    logic            path_bit;
    logic [CW-1:0]   lslot;
    logic [CW-1:0]   rslot;

    assign acc_hit = i_acc_rd && (i_acc_lvl == MY_LVL);

    always_comb begin
        rd_en = acc_hit;
        raddr = AW'(i_acc_idx >> 1);
        if (i_tok.valid) begin
            rd_en = (i_tok.op != TOK_ROOT);
            raddr = (i_tok.op == TOK_SIFT) ? AW'(i_idx) : AW'(i_idx >> 1);
        end
    end

    // write-back from below never lands in the same cycle as our own write
    assign wr_en  = i_wb.valid || own_en;
    assign wr_idx = i_wb.valid ? i_wb_idx : own_idx;
    assign wr_ent = i_wb.valid ? i_wb.ent : own_ent;
    assign waddr  = AW'(wr_idx >> 1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (wr_idx[0]) begin
                mem_r[waddr] <= wr_ent;
            end else begin
                mem_l[waddr] <= wr_ent;
            end
        end
        if (rd_en) begin
            r_rd_l <= mem_l[raddr];
            r_rd_r <= mem_r[raddr];
        end
        if (acc_hit) begin
            r_side <= i_acc_idx[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_idx <= i_idx;
        end
    end

    assign o_acc_ent = r_side ? r_rd_r : r_rd_l;

    always_comb begin
        node     = r_idx[0] ? r_rd_r : r_rd_l;
        lslot    = BASE + CW'({r_idx, 1'b0});
        rslot    = lslot + CW'(1);
        lv       = lslot < i_cnt;
        rv       = rslot < i_cnt;
        pick_r   = rv && (r_rd_l.prio < r_rd_r.prio);
        pick     = pick_r ? r_rd_r : r_rd_l;
        path_bit = i_path[PB];

        own_en   = 1'b0;
        own_idx  = r_idx;
        own_ent  = r_tok.ent;
        o_tok    = '0;
        o_idx    = '0;
        o_wb     = '0;
        o_wb_idx = '0;
        o_done   = 1'b0;

        if (r_tok.valid) begin
            unique case (r_tok.op)
                TOK_INS: begin
                    if (i_tgt_lvl == MY_LVL) begin
                        // free slot at the end of the heap
                        own_en = 1'b1;
                        o_done = 1'b1;
                    end else begin
                        o_tok.valid = 1'b1;
                        o_tok.op    = TOK_INS;
                        o_idx       = IW'({r_idx, path_bit});
                        if (r_tok.shift || (node.prio < r_tok.ent.prio)) begin
                            // take this slot, push the old entry down the path
                            own_en      = 1'b1;
                            o_tok.shift = 1'b1;
                            o_tok.ent   = node;
                        end else begin
                            o_tok.shift = 1'b0;
                            o_tok.ent   = r_tok.ent;
                        end
                    end
                end
                TOK_ROOT: begin
                    own_en      = 1'b1;
                    o_tok.valid = 1'b1;
                    o_tok.op    = TOK_SIFT;
                    o_tok.ent   = r_tok.ent;
                    o_idx       = r_idx;
                end
                TOK_SIFT: begin
                    if (lv && (r_tok.ent.prio < pick.prio)) begin
                        own_en      = 1'b1;
                        own_idx     = IW'({r_idx, pick_r});
                        o_wb.valid  = 1'b1;
                        o_wb.ent    = pick;
                        o_wb_idx    = r_idx;
                        if (LEVEL == LEVELS - 1) begin
                            o_done = 1'b1;
                        end else begin
                            o_tok.valid = 1'b1;
                            o_tok.op    = TOK_SIFT;
                            o_tok.ent   = r_tok.ent;
                            o_idx       = IW'({r_idx, pick_r});
                        end
                    end else begin
                        o_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
